@@ design/dds_channel_program_sequencer_core_defines.svh @@
// Assertion macros used by the sequencer core.
`ifndef DDS_CHANNEL_PROGRAM_SEQUENCER_CORE_DEFINES_SVH
`define DDS_CHANNEL_PROGRAM_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DCPS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("dcps: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define DCPS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("dcps: next-cycle check failed");

`endif

@@ design/dcps_pkg.sv @@
package dcps_pkg;

   typedef struct packed {
      logic [1:0]  channel_code;
      logic [27:0] frequency_hz;
      logic [9:0]  phase_degrees;
   } req_type;

   typedef struct packed {
      logic [7:0]  reg_address;
      logic [31:0] reg_data;
      logic [5:0]  data_bits;
      logic        last_frame;
   } rsp_type;

   // One classified request waiting for the frame sequencer.
   typedef struct packed {
      logic [1:0]  code;
      logic [31:0] ftw;
      logic [15:0] pw_first;
      logic [15:0] pw_second;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam logic [1:0] CODE_CH0    = 2'd0;
   localparam logic [1:0] CODE_CH1    = 2'd1;
   localparam logic [1:0] CODE_BOTH   = 2'd2;
   localparam logic [1:0] CODE_IGNORE = 2'd3;

   localparam logic [1:0] SLOT_SELECT    = 2'd0;
   localparam logic [1:0] SLOT_AMPLITUDE = 2'd1;
   localparam logic [1:0] SLOT_FREQUENCY = 2'd2;
   localparam logic [1:0] SLOT_PHASE     = 2'd3;

   localparam int unsigned FREQ_W   = 28;
   localparam logic [27:0] FREQ_MAX = 28'd250000000;

   localparam logic [7:0] ADDR_CSR  = 8'h00;
   localparam logic [7:0] ADDR_CFTW = 8'h04;
   localparam logic [7:0] ADDR_CPOW = 8'h05;
   localparam logic [7:0] ADDR_ACR  = 8'h06;

   localparam logic [7:0] SEL_CH0 = 8'h40;
   localparam logic [7:0] SEL_CH1 = 8'h80;

   localparam logic [5:0] BITS_SELECT    = 6'd8;
   localparam logic [5:0] BITS_PHASE     = 6'd16;
   localparam logic [5:0] BITS_AMPLITUDE = 6'd24;
   localparam logic [5:0] BITS_FREQUENCY = 6'd32;

   localparam logic [10:0] QUAD_OFFSET = 11'd90;

   localparam int unsigned WORD_W        = 32;
   localparam int unsigned AMP_W         = 24;
   localparam logic [23:0] AMP_RESET     = 24'd439;
   // p * 16384 / 360 == (p << 11) / 45 == (p * ceil(2^28 / 45)) >> 17 for p below 2048.
   localparam logic [22:0] PHASE_RECIP   = 23'd5965233;
   localparam int unsigned PHASE_SHIFT   = 17;
   localparam int unsigned PHASE_PROD_W  = 34;

   localparam int unsigned DIV_STAGES = 4;
   localparam int unsigned GROUP_W    = 3;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = 1;
   localparam int unsigned QCOUNT_W    = 2;

endpackage

@@ design/dcps_ldiv.sv @@
module dcps_ldiv import dcps_pkg::*; #(
   parameter int unsigned DIVISOR = 500000000
) (
   input  logic              clock,
   input  logic              load,
   input  logic              advance,
   input  logic [FREQ_W-1:0] numerator,
   output logic [WORD_W-1:0] quotient
);

   // All ones over the divisor is within two of 2^64 over the divisor, so the
   // product below is at most one short of the true quotient.
   localparam logic [63:0]       RECIP        = 64'hFFFF_FFFF_FFFF_FFFF / 64'(DIVISOR);
   localparam logic [WORD_W-1:0] RECIP_HI     = RECIP[63:32];
   localparam logic [WORD_W-1:0] RECIP_LO     = RECIP[31:0];
   localparam logic [WORD_W-1:0] DIVISOR_WORD = WORD_W'(DIVISOR);

   logic [FREQ_W-1:0] num_ff;
   logic [WORD_W-1:0] hi_ff;
   logic [WORD_W-1:0] lo_ff;
   logic [WORD_W-1:0] est_ff;
   logic [WORD_W-1:0] est_hold_ff;
   logic [WORD_W-1:0] rem_ff;
   logic [WORD_W-1:0] quot_ff;

   logic [63:0]       lo_prod;
   logic [WORD_W-1:0] hi_prod;
   logic [WORD_W-1:0] back_prod;

   // Quotient of numerator * 2^32 by the divisor, for numerators below the divisor.
   // The low 32 bits of numerator * 2^32 are zero, so the remainder of the estimate
   // is the negated low word of estimate * divisor; one at or above the divisor
   // means the estimate is one short. Every stage moves on advance; after a load the value
   // passes the hi and lo products, the estimate, the held estimate with the remainder, then the quotient.
   assign lo_prod   = 64'(num_ff) * 64'(RECIP_LO);
   assign hi_prod   = WORD_W'(num_ff) * RECIP_HI;
   assign back_prod = est_ff * DIVISOR_WORD;

   always_ff @(posedge clock) begin
      if (load) begin
         num_ff <= numerator;
      end
      if (advance) begin
         hi_ff       <= hi_prod;
         lo_ff       <= lo_prod[63:32];
         est_ff      <= hi_ff + lo_ff;
         est_hold_ff <= est_ff;
         rem_ff      <= -back_prod;
         quot_ff     <= est_hold_ff + WORD_W'(rem_ff >= DIVISOR_WORD);
      end
   end

   assign quotient = quot_ff;

endmodule

@@ design/dcps_front.sv @@
module dcps_front import dcps_pkg::*; #(
   parameter int unsigned SYS_CLOCK_HZ = 500000000
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   input  queue_status_type q_status,
   output logic             push,
   output entry_type        entry
);

   localparam logic [WORD_W-1:0]  SYS_CLOCK_WORD = WORD_W'(SYS_CLOCK_HZ);
   localparam logic [GROUP_W-1:0] STAGE_LAST     = GROUP_W'(DIV_STAGES - 1);

   logic               busy_ff;
   logic               done_ff;
   logic [GROUP_W-1:0] cnt_ff;
   logic [1:0]         code_ff;
   logic               sat_ff;
   logic [15:0]        pw_first_ff;
   logic [15:0]        pw_second_ff;

   logic                    accept;
   logic                    advance;
   logic                    sat_in;
   logic [FREQ_W-1:0]       f_clamp;
   logic [10:0]             phase_quad;
   logic [PHASE_PROD_W-1:0] ph_first_prod;
   logic [PHASE_PROD_W-1:0] ph_second_prod;
   logic [WORD_W-1:0]       freq_q;

   assign f_clamp    = (req_item.frequency_hz > FREQ_MAX) ? FREQ_MAX
                                                          : req_item.frequency_hz;
   // The tuning word passes 32 bits exactly when the frequency reaches the clock.
   assign sat_in     = WORD_W'(f_clamp) >= SYS_CLOCK_WORD;
   assign phase_quad = {1'b0, req_item.phase_degrees} + QUAD_OFFSET;

   assign ph_first_prod  = PHASE_PROD_W'(req_item.phase_degrees)
                           * PHASE_PROD_W'(PHASE_RECIP);
   assign ph_second_prod = PHASE_PROD_W'(phase_quad) * PHASE_PROD_W'(PHASE_RECIP);

   assign push    = busy_ff && done_ff && !q_status.full;
   assign busy    = busy_ff && !push;
   assign accept  = start && !busy;
   assign advance = busy_ff && !done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (accept) begin
         busy_ff <= (req_item.channel_code != CODE_IGNORE);
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (push) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (advance) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == STAGE_LAST) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff      <= req_item.channel_code;
         sat_ff       <= sat_in;
         pw_first_ff  <= ph_first_prod[PHASE_SHIFT +: 16];
         pw_second_ff <= ph_second_prod[PHASE_SHIFT +: 16];
      end
   end

   dcps_ldiv #(
      .DIVISOR (SYS_CLOCK_HZ)
   ) u_freq_div (
      .clock     (clock),
      .load      (accept),
      .advance   (advance),
      .numerator (f_clamp),
      .quotient  (freq_q)
   );

   assign entry.code      = code_ff;
   assign entry.ftw       = sat_ff ? '1 : freq_q;
   assign entry.pw_first  = pw_first_ff;
   assign entry.pw_second = pw_second_ff;

endmodule

@@ design/dcps_queue.sv @@
module dcps_queue import dcps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        entry_in,
   input  logic             pop,
   output queue_status_type q_status,
   output entry_type        entry_out
);

   entry_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCOUNT_W-1:0] count_ff;

   assign q_status.full  = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign entry_out      = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

@@ design/dcps_back.sv @@
module dcps_back import dcps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  entry_type        q_entry,
   input  logic [AMP_W-1:0] amplitude,
   output logic             pop,
   output logic             rsp_strobe,
   output rsp_type          rsp_frame
);

   logic               active_ff;
   logic               strobe_ff;
   logic [GROUP_W-1:0] cnt_ff;
   entry_type          entry_ff;
   rsp_type            frame_ff;
   rsp_type            frame_in;

   logic               second_group;
   logic [1:0]         slot;
   logic               final_frame;
   logic               finishing;
   logic [7:0]         sel;

   assign second_group = cnt_ff[GROUP_W-1];
   assign slot         = cnt_ff[1:0];
   assign final_frame  = (slot == SLOT_PHASE) && (second_group || entry_ff.code != CODE_BOTH);
   assign finishing    = active_ff && final_frame;
   // The next request is taken in the cycle the last frame of this one is registered.
   assign pop          = !q_status.empty && (!active_ff || finishing);
   assign sel          = (second_group || entry_ff.code == CODE_CH1) ? SEL_CH1 : SEL_CH0;

   always_comb begin
      frame_in.last_frame = final_frame;
      case (slot)
         SLOT_SELECT: begin
            frame_in.reg_address = ADDR_CSR;
            frame_in.reg_data    = WORD_W'(sel);
            frame_in.data_bits   = BITS_SELECT;
         end
         SLOT_AMPLITUDE: begin
            frame_in.reg_address = ADDR_ACR;
            frame_in.reg_data    = WORD_W'(amplitude);
            frame_in.data_bits   = BITS_AMPLITUDE;
         end
         SLOT_FREQUENCY: begin
            frame_in.reg_address = ADDR_CFTW;
            frame_in.reg_data    = entry_ff.ftw;
            frame_in.data_bits   = BITS_FREQUENCY;
         end
         default: begin
            frame_in.reg_address = ADDR_CPOW;
            frame_in.reg_data    = WORD_W'(second_group ? entry_ff.pw_second : entry_ff.pw_first);
            frame_in.data_bits   = BITS_PHASE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         strobe_ff <= active_ff;
         if (pop) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
         end else if (finishing) begin
            active_ff <= 1'b0;
         end else if (active_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         entry_ff <= q_entry;
      end
      if (active_ff) begin
         frame_ff <= frame_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_frame  = frame_ff;

endmodule

@@ design/dds_channel_program_sequencer_core.sv @@
// The front works on one request at a time through the 4-stage tuning word divider and holds
// busy while the queue is full; frames of a request leave one a cycle, 4 for channel 0 or 1
// and 8 for both. The ignore code gives no frames and frees the input at once.
// Frames cannot be stalled; a two-entry queue lets the front compute while frames go out.
// Reset is synchronous: queue and sequencer empty, amplitude word back to 439.
`include "dds_channel_program_sequencer_core_defines.svh"

module dds_channel_program_sequencer_core import dcps_pkg::*; #(
   parameter int unsigned SYS_CLOCK_HZ = 500000000
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   output logic             rsp_strobe,
   output rsp_type          rsp_frame,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [AMP_W-1:0] csr_data
);

   logic [AMP_W-1:0] amp_ff;
   logic             push;
   logic             pop;
   queue_status_type q_status;
   entry_type        front_entry;
   entry_type        queue_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= AMP_RESET;
      end else if (csr_valid && csr_ready) begin
         amp_ff <= csr_data;
      end
   end

   dcps_front #(
      .SYS_CLOCK_HZ (SYS_CLOCK_HZ)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_status (q_status),
      .push     (push),
      .entry    (front_entry)
   );

   dcps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_in  (front_entry),
      .pop       (pop),
      .q_status  (q_status),
      .entry_out (queue_entry)
   );

   dcps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_entry    (queue_entry),
      .amplitude  (amp_ff),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_frame  (rsp_frame)
   );

   `DCPS_ASSERT_NEXT(a_busy_after_request, clock, reset, start && !busy && req_item.channel_code != CODE_IGNORE, busy)
   `DCPS_ASSERT_IMPLY(a_last_is_phase, clock, reset, rsp_strobe && rsp_frame.last_frame, rsp_frame.reg_address == ADDR_CPOW)
   `DCPS_ASSERT_NEXT(a_select_then_amp, clock, reset, rsp_strobe && rsp_frame.reg_address == ADDR_CSR, rsp_strobe && rsp_frame.reg_address == ADDR_ACR)

endmodule

@@ test/tb_dds_channel_program_sequencer_core.sv @@
`timescale 1ns / 1ps

module tb_dds_channel_program_sequencer_core;
   import dcps_pkg::*;

   localparam int unsigned SYS_CLOCK_HZ  = 500000000;
   localparam int unsigned RANDOM_ITEMS  = 370;
   localparam int unsigned DRAIN_CYCLES  = 24;
   localparam int unsigned LIMIT_CYCLES  = 400000;

   // Holds the frames the sequencer owes and the amplitude word it should be using.
   class frame_scoreboard;
      rsp_type          owed_frames[$];
      logic [AMP_W-1:0] amplitude;
      int unsigned      error_count;
      int unsigned      frame_count;
      int unsigned      request_count;
      int unsigned      ignored_count;

      function new();
         amplitude     = AMP_RESET;
         error_count   = 0;
         frame_count   = 0;
         request_count = 0;
         ignored_count = 0;
      endfunction

      function logic [15:0] phase_word(logic [10:0] degrees);
         logic [31:0] scaled;
         scaled = (32'(degrees) * 32'd16384) / 32'd360;
         return scaled[15:0];
      endfunction

      function void push_frame(logic [7:0] addr, logic [31:0] data, logic [5:0] bits,
                               logic last);
         rsp_type f;
         f.reg_address = addr;
         f.reg_data    = data;
         f.data_bits   = bits;
         f.last_frame  = last;
         owed_frames.push_back(f);
      endfunction

      function void push_channel(logic [7:0] sel, logic [31:0] ftw, logic [15:0] pw,
                                 logic last);
         push_frame(ADDR_CSR, {24'd0, sel}, BITS_SELECT, 1'b0);
         push_frame(ADDR_ACR, {8'd0, amplitude}, BITS_AMPLITUDE, 1'b0);
         push_frame(ADDR_CFTW, ftw, BITS_FREQUENCY, 1'b0);
         push_frame(ADDR_CPOW, {16'd0, pw}, BITS_PHASE, last);
      endfunction

      function void note_request(req_type r);
         logic [27:0] freq;
         logic [63:0] wide;
         logic [31:0] ftw;
         request_count++;
         freq = (r.frequency_hz > FREQ_MAX) ? FREQ_MAX : r.frequency_hz;
         wide = ({36'd0, freq} << 32) / 64'(SYS_CLOCK_HZ);
         ftw  = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
         case (r.channel_code)
            CODE_CH0: begin
               push_channel(SEL_CH0, ftw, phase_word(11'(r.phase_degrees)), 1'b1);
            end
            CODE_CH1: begin
               push_channel(SEL_CH1, ftw, phase_word(11'(r.phase_degrees)), 1'b1);
            end
            CODE_BOTH: begin
               push_channel(SEL_CH0, ftw, phase_word(11'(r.phase_degrees)), 1'b0);
               push_channel(SEL_CH1, ftw,
                            phase_word(11'(r.phase_degrees) + QUAD_OFFSET), 1'b1);
            end
            default: begin
               ignored_count++;
            end
         endcase
      endfunction

      function void check_frame(rsp_type got);
         rsp_type want;
         frame_count++;
         if (owed_frames.size() == 0) begin
            $error("unexpected frame: addr %0h data %0h bits %0d last %0b",
                   got.reg_address, got.reg_data, got.data_bits, got.last_frame);
            error_count++;
         end else begin
            want = owed_frames.pop_front();
            if (got.reg_address !== want.reg_address) begin
               $error("reg_address: expected %0h, actual %0h", want.reg_address,
                      got.reg_address);
               error_count++;
            end
            if (got.reg_data !== want.reg_data) begin
               $error("reg_data: expected %0h, actual %0h", want.reg_data, got.reg_data);
               error_count++;
            end
            if (got.data_bits !== want.data_bits) begin
               $error("data_bits: expected %0d, actual %0d", want.data_bits,
                      got.data_bits);
               error_count++;
            end
            if (got.last_frame !== want.last_frame) begin
               $error("last_frame: expected %0b, actual %0b", want.last_frame,
                      got.last_frame);
               error_count++;
            end
         end
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             start      = 1'b0;
   logic             busy;
   req_type          req_item   = '0;
   logic             rsp_strobe;
   rsp_type          rsp_frame;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [AMP_W-1:0] csr_data   = '0;

   frame_scoreboard sb = new();
   bit              start_held = 1'b0;
   int unsigned     amp_settings = 0;

   dds_channel_program_sequencer_core #(.SYS_CLOCK_HZ(SYS_CLOCK_HZ)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_frame  (rsp_frame),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_frame(rsp_frame);
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   // Lowers start once; a following request in the same step raises it instead.
   task automatic release_start();
      if (start_held) begin
         start      <= 1'b0;
         start_held = 1'b0;
      end
   endtask

   task automatic send_request(req_type r);
      start      <= 1'b1;
      req_item   <= r;
      start_held = 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   task automatic send(logic [1:0] code, logic [27:0] freq, logic [9:0] phase);
      req_type r;
      r.channel_code  = code;
      r.frequency_hz  = freq;
      r.phase_degrees = phase;
      send_request(r);
   endtask

   task automatic idle_gap(bit allow_gaps);
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(0, 19);
      if (!allow_gaps || pick < 8)
         n = 0;
      else if (pick < 18)
         n = $urandom_range(1, 4);
      else
         n = $urandom_range(10, 40);
      if (n > 0) begin
         release_start();
         repeat (n) @(posedge clock);
      end
   endtask

   // Lowers start and waits out every owed frame, then the pipeline depth.
   task automatic drain();
      release_start();
      while (sb.owed_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_amplitude(logic [AMP_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.amplitude = value;
      amp_settings++;
   endtask

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      r.channel_code = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      case (pick)
         0:       r.frequency_hz = FREQ_MAX;
         1:       r.frequency_hz = 28'($urandom_range(250000001, 268435455));
         2:       r.frequency_hz = 28'($urandom_range(0, 1000));
         default: r.frequency_hz = 28'($urandom_range(0, 250000000));
      endcase
      if ($urandom_range(0, 4) == 0)
         r.phase_degrees = 10'($urandom_range(720, 1023));
      else
         r.phase_degrees = 10'($urandom_range(0, 719));
      return r;
   endfunction

   initial begin
      logic [AMP_W-1:0] amp_plan[5];
      int unsigned      counted;
      int unsigned      target;
      req_type          r;

      amp_plan[0] = 24'h000000;
      amp_plan[1] = 24'hFFFFFF;
      amp_plan[2] = 24'($urandom_range(1, 24'hFFFFFE));
      amp_plan[3] = 24'($urandom_range(1, 24'hFFFFFE));
      amp_plan[4] = 24'($urandom_range(1, 24'hFFFFFE));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests at the reset amplitude word.
      send(CODE_CH0, 28'd0, 10'd0);
      send(CODE_CH1, 28'd0, 10'd0);
      send(CODE_BOTH, 28'd0, 10'd0);
      send(CODE_IGNORE, 28'd0, 10'd0);
      send(CODE_CH0, FREQ_MAX, 10'd719);
      send(CODE_CH1, FREQ_MAX, 10'd719);
      send(CODE_BOTH, FREQ_MAX, 10'd719);
      send(CODE_CH0, 28'd250000001, 10'd1023);
      send(CODE_BOTH, 28'hFFFFFFF, 10'd1023);
      send(CODE_IGNORE, 28'hFFFFFFF, 10'h3FF);
      send(CODE_CH1, 28'd1, 10'd1);
      send(CODE_CH0, 28'd125000000, 10'd360);
      send(CODE_BOTH, 28'd1000000, 10'd630);
      send(CODE_BOTH, 28'd12345678, 10'd359);
      send(CODE_CH1, 28'h5555555, 10'h2AA);
      send(CODE_CH0, 28'hAAAAAAA, 10'h155);
      idle_gap(1'b1);
      send(CODE_IGNORE, 28'd100, 10'd45);
      send(CODE_CH0, 28'd100, 10'd45);

      for (int ph = 0; ph < 5; ph++) begin
         write_amplitude(amp_plan[ph]);
         send(CODE_BOTH, FREQ_MAX, 10'd719);
         counted = 0;
         target  = RANDOM_ITEMS / 5;
         while (counted < target) begin
            r = random_request();
            send_request(r);
            counted++;
            if (counted == target / 2)
               drain();
            else
               idle_gap(ph != 1);
         end
      end

      write_amplitude(AMP_RESET);
      send(CODE_CH1, 28'd1, 10'd1);
      drain();

      $display("Sent %0d requests (%0d of them ignored) and checked %0d frames",
               sb.request_count, sb.ignored_count, sb.frame_count);
      $display("over %0d amplitude settings, including zero and full scale.", amp_settings);
      if (sb.error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ dds_channel_program_sequencer_core.f @@
+incdir+design
design/dcps_pkg.sv
design/dcps_ldiv.sv
design/dcps_front.sv
design/dcps_queue.sv
design/dcps_back.sv
design/dds_channel_program_sequencer_core.sv
test/tb_dds_channel_program_sequencer_core.sv
